// ===== src/sha512_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-512 compression package
// Round constants, initial hash values, sigma functions and sequencer states.
// ---------------------------------------------------------------------------
package sha512_pkg;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   localparam logic [0:0] REG_HASH_MODE = 1'b0;

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam logic [63:0] IV_384 [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam logic [63:0] IV_512 [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
      rotr = (v >> n) | (v << (64 - n));
   endfunction

   function automatic logic [63:0] big_sigma0(input logic [63:0] v);
      big_sigma0 = rotr(v, 28) ^ rotr(v, 34) ^ rotr(v, 39);
   endfunction

   function automatic logic [63:0] big_sigma1(input logic [63:0] v);
      big_sigma1 = rotr(v, 14) ^ rotr(v, 18) ^ rotr(v, 41);
   endfunction

   function automatic logic [63:0] small_sigma0(input logic [63:0] v);
      small_sigma0 = rotr(v, 1) ^ rotr(v, 8) ^ (v >> 7);
   endfunction

   function automatic logic [63:0] small_sigma1(input logic [63:0] v);
      small_sigma1 = rotr(v, 19) ^ rotr(v, 61) ^ (v >> 6);
   endfunction

endpackage

// ===== src/sha512_block_compression.sv =====
// ---------------------------------------------------------------------------
// SHA-512 block compression
// Takes padded 64-bit message words, runs the 80-round compression after each
// sixteenth word and emits the eight digest words after a final block.
// ---------------------------------------------------------------------------
// A word is taken whenever one is offered while the block loads; the sixteenth
// word of a block starts the compression, which runs one round per cycle
// through a single round unit and then adds into the chaining value. After a
// final block the eight digest words leave one per cycle while rsp_stall is
// low, read from the chaining value registers, and no word is accepted until
// the last one is taken. hash_mode lies at address 0.
module sha512_block_compression (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_msg_word,
   input  logic        req_new_message,
   input  logic        req_final_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [0:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sha512_pkg::*;

   state_type   state_ff, state_in;
   logic        mode_ff;
   logic [63:0] chain_ff [8];
   logic [63:0] win_ff [16];
   logic [63:0] wv_ff [8];
   logic [3:0]  wcnt_ff;
   logic [6:0]  rnd_ff;
   logic        fin_ff;
   logic [2:0]  oidx_ff;
   logic        ovalid_ff;

   logic        req_fire, rsp_fire;
   logic [63:0] w_cur, t1, t2, e, a;
   logic [3:0]  r4;

   assign pready    = 1'b1;
   assign prdata    = {31'd0, mode_ff};
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = ovalid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = ovalid_ff;
   assign rsp_word_index  = oidx_ff;
   assign rsp_last        = (oidx_ff == 3'd7);
   assign rsp_digest_word = chain_ff[oidx_ff];

   // one round: schedule word plus round function
   always_comb begin
      r4 = rnd_ff[3:0];
      if (rnd_ff < 7'd16) begin
         w_cur = win_ff[r4];
      end else begin
         w_cur = small_sigma1(win_ff[r4 - 4'd2]) + win_ff[r4 - 4'd7]
               + small_sigma0(win_ff[r4 - 4'd15]) + win_ff[r4];
      end
      e  = wv_ff[4];
      a  = wv_ff[0];
      t1 = wv_ff[7] + big_sigma1(e) + ((e & wv_ff[5]) ^ (~e & wv_ff[6]))
         + ROUND_K[rnd_ff] + w_cur;
      t2 = big_sigma0(a) + ((a & wv_ff[1]) ^ (a & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && wcnt_ff == 4'd15) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == 7'd79) state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = fin_ff ? ST_EMIT : ST_LOAD;
         end
         ST_EMIT: begin
            if (rsp_fire && oidx_ff == 3'd7) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         mode_ff   <= 1'b1;
         wcnt_ff   <= '0;
         rnd_ff    <= '0;
         oidx_ff   <= '0;
         ovalid_ff <= 1'b0;
         fin_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (psel && penable && pwrite && paddr == REG_HASH_MODE) mode_ff <= pwdata[0];
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (wcnt_ff == 4'd0 && req_new_message) begin
                     for (int i = 0; i < 8; i++) chain_ff[i] <= mode_ff ? IV_512[i] : IV_384[i];
                  end
                  wcnt_ff <= wcnt_ff + 4'd1;
                  if (wcnt_ff == 4'd15) begin
                     fin_ff <= req_final_block;
                     rnd_ff <= '0;
                  end
               end
            end
            ST_ROUND: begin
               rnd_ff <= (rnd_ff == 7'd79) ? 7'd0 : rnd_ff + 7'd1;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + wv_ff[i];
               ovalid_ff <= fin_ff;
               oidx_ff   <= '0;
            end
            ST_EMIT: begin
               if (rsp_fire) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) ovalid_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // payload storage: message window and working variables
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && req_fire) begin
         win_ff[wcnt_ff] <= req_msg_word;
         if (wcnt_ff == 4'd15) begin
            // chaining value is stable here unless a new message loads on word 0,
            // which happened fifteen words ago
            for (int i = 0; i < 8; i++) wv_ff[i] <= chain_ff[i];
         end
      end else if (state_ff == ST_ROUND) begin
         if (rnd_ff >= 7'd16) win_ff[r4] <= w_cur;
         for (int i = 7; i > 0; i--) wv_ff[i] <= wv_ff[i-1];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[0] <= t1 + t2;
      end
   end

endmodule

// ===== src/sha512_chk.sv =====
// ---------------------------------------------------------------------------
// SHA-512 compression port checker
// Watches the top-level ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
module sha512_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_word_index,
   input logic       rsp_last
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_index))
      else $error("stalled digest word changed");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_word_index == 3'd7)))
      else $error("last flag misplaced");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("word accepted during digest output");
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid
         && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest words out of order");
endmodule

bind sha512_block_compression sha512_chk u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_word_index(rsp_word_index), .rsp_last(rsp_last)
);
